@@ hw/rtl/brfp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package brfp_pkg;

   // Store geometry
   localparam int DEPTH  = 256;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int SIZE_W = PTR_W + 1;

   // Field widths
   localparam int BYTE_W = 8;
   localparam int CNT_W  = 8;
   localparam int CAP_W  = 9;

   localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);
   localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(DEPTH);
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);
   localparam logic [CNT_W-1:0] PROG_MAX  = {CNT_W{1'b1}};

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_PEEK  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      op_type              req_type;
      logic [BYTE_W-1:0]   write_byte;
      logic                burst_last;
   } req_pkt_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   read_byte;
      logic                done_res;
      logic [CNT_W-1:0]    used_count;
      logic [CNT_W-1:0]    free_count;
      logic [CNT_W-1:0]    transfer_count;
   } rsp_pkt_type;

endpackage

`default_nettype wire

@@ hw/rtl/brfp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module brfp_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 256,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/byte_ring_fifo_with_peek.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Byte ring FIFO with peek, one slot of the active ring always kept empty.
// Latency: the response strobe is registered and rises in the cycle after the request is taken.
// Throughput: 1 request per cycle; busy stays low, the single store read
//   port and the registered pointer update set this figure.
// Reset: positions and call progress clear, capacity goes to 256, store
//   contents stay undefined until written. No clearing pass is needed.
module byte_ring_fifo_with_peek (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire brfp_pkg::req_pkt_type        req_data,
   output logic                              rsp_strobe,
   output brfp_pkg::rsp_pkt_type             rsp_data,
   input  wire logic                         csr_wr_en,
   input  wire logic [brfp_pkg::CAP_W-1:0]   csr_wr_data
);

   import brfp_pkg::*;

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   logic [CAP_W-1:0]  cap_ff;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [CNT_W-1:0]  prog_ff, prog_in;

   // Response stage: everything but the byte, which comes from the store
   logic              rsp_strobe_ff;
   logic              byte_sel_ff;
   rsp_pkt_type       rsp_ff, rsp_in;

   logic              accept;
   logic [SIZE_W-1:0] size_w;
   logic [SIZE_W-1:0] used_w;
   logic [SIZE_W-1:0] used_after;
   logic [SIZE_W-1:0] peek_sum;
   logic [PTR_W-1:0]  peek_addr;
   logic [PTR_W-1:0]  wp_inc, rp_inc;
   logic              wr_ok, rd_ok, pk_ok;
   logic              done_w;
   logic [CNT_W-1:0]  count_w;

   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [PTR_W-1:0]  ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   // Every request finishes in one pass, so the block never holds off start.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // ------------------------------------------------------------------
   // Ring geometry: clamp the capacity register into 2..DEPTH
   // ------------------------------------------------------------------
   always_comb begin
      priority if (cap_ff < CAP_MIN) begin
         size_w = SIZE_W'(CAP_MIN);
      end else if (cap_ff > CAP_MAX) begin
         size_w = SIZE_W'(CAP_MAX);
      end else begin
         size_w = SIZE_W'(cap_ff);
      end
   end

   // Positions always stay below the ring size (a capacity write zeroes
   // them), so the held count needs only one wrap correction.
   always_comb begin
      if (wp_ff >= rp_ff) begin
         used_w = SIZE_W'(wp_ff) - SIZE_W'(rp_ff);
      end else begin
         used_w = SIZE_W'(wp_ff) + size_w - SIZE_W'(rp_ff);
      end
   end

   // Advance a position by one and wrap at the ring size
   assign wp_inc = (SIZE_W'(wp_ff) + SIZE_W'(1) == size_w) ? '0 : wp_ff + PTR_W'(1);
   assign rp_inc = (SIZE_W'(rp_ff) + SIZE_W'(1) == size_w) ? '0 : rp_ff + PTR_W'(1);

   // Peek address: read position plus call progress, below twice the size when the peek succeeds
   assign peek_sum  = SIZE_W'(rp_ff) + SIZE_W'(prog_ff);
   assign peek_addr = (peek_sum >= size_w) ? PTR_W'(peek_sum - size_w)
                                           : PTR_W'(peek_sum);

   // Room check keeps the one reserved slot empty
   assign wr_ok = (used_w < size_w - SIZE_W'(1));
   assign rd_ok = (used_w != '0);
   assign pk_ok = (SIZE_W'(prog_ff) < used_w);

   // ------------------------------------------------------------------
   // Request decode and next state
   // ------------------------------------------------------------------
   always_comb begin
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      done_w     = 1'b0;
      used_after = used_w;
      ram_wr_en  = 1'b0;
      ram_rd_en  = 1'b0;
      ram_rd_addr = rp_ff;

      unique case (req_data.req_type)
         OP_WRITE: begin
            if (wr_ok) begin
               wp_in      = wp_inc;
               done_w     = 1'b1;
               used_after = used_w + SIZE_W'(1);
               ram_wr_en  = accept;
            end
         end
         OP_READ: begin
            if (rd_ok) begin
               rp_in      = rp_inc;
               done_w     = 1'b1;
               used_after = used_w - SIZE_W'(1);
               ram_rd_en  = accept;
            end
         end
         OP_PEEK: begin
            ram_rd_addr = peek_addr;
            if (pk_ok) begin
               done_w    = 1'b1;
               ram_rd_en = accept;
            end
         end
         OP_CLEAR: begin
            wp_in      = '0;
            rp_in      = '0;
            used_after = '0;
         end
         default: begin
            wp_in = wp_ff;
         end
      endcase

      // Count done bytes of the call; saturate instead of wrapping
      if (req_data.req_type == OP_CLEAR) begin
         count_w = '0;
      end else if (done_w && (prog_ff != PROG_MAX)) begin
         count_w = prog_ff + CNT_W'(1);
      end else begin
         count_w = prog_ff;
      end

      // Drop the running count once the call ends
      if (req_data.burst_last || (req_data.req_type == OP_CLEAR)) begin
         prog_in = '0;
      end else begin
         prog_in = count_w;
      end

      rsp_in.read_byte      = '0;
      rsp_in.done_res       = done_w;
      rsp_in.used_count     = CNT_W'(used_after);
      rsp_in.free_count     = CNT_W'(size_w - SIZE_W'(1) - used_after);
      rsp_in.transfer_count = count_w;
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= CAP_RESET;
         wp_ff         <= '0;
         rp_ff         <= '0;
         prog_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
         // A capacity write also empties the queue
         if (csr_wr_en) begin
            cap_ff  <= csr_wr_data;
            wp_ff   <= '0;
            rp_ff   <= '0;
            prog_ff <= '0;
         end else if (accept) begin
            wp_ff   <= wp_in;
            rp_ff   <= rp_in;
            prog_ff <= prog_in;
         end
      end
   end

   // Response payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff      <= rsp_in;
         byte_sel_ff <= ram_rd_en;
      end
   end

   // ------------------------------------------------------------------
   // Byte store
   // ------------------------------------------------------------------
   brfp_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (req_data.write_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Merge the store output into the response; zero when nothing was read
   always_comb begin
      rsp_data           = rsp_ff;
      rsp_data.read_byte = byte_sel_ff ? ram_rd_data : '0;
   end

   assign rsp_strobe = rsp_strobe_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_one_rsp_per_req: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("request taken without a response strobe");

   a_ptr_in_ring: assert property (@(posedge clock) disable iff (reset)
      (SIZE_W'(wp_ff) < size_w) && (SIZE_W'(rp_ff) < size_w))
      else $error("ring position outside the active ring");

   a_slot_reserved: assert property (@(posedge clock) disable iff (reset)
      used_w < size_w)
      else $error("held count reached the ring size");

   a_done_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.done_res) |-> (rsp_data.transfer_count != '0))
      else $error("done response with zero transfer count");

endmodule

`default_nettype wire
